@@ sv/ctcg_pkg.sv @@
// ----------------------------------------------------------------------------
// ctcg_pkg
// Shared types, constants and the exp(-n/256) table for the CTC greedy decoder.
// ----------------------------------------------------------------------------
package ctcg_pkg;

  localparam int DEF_MAX_VOCAB  = 64;
  localparam int DEF_MAX_FRAMES = 1024;

  localparam int LOGIT_W = 16;
  localparam int TOK_W   = 6;
  localparam int CONF_W  = 16;
  localparam int TERM_W  = 17;
  localparam int Q30_W   = 31;
  localparam int DIV_NW  = 33;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int RST_BLANK  = 53;
  localparam int RST_VOCAB  = 56;
  localparam int RST_FRAMES = 149;
  localparam int RST_LAST   = 51;

  localparam logic [1:0] REG_BLANK  = 2'd0;
  localparam logic [1:0] REG_VOCAB  = 2'd1;
  localparam logic [1:0] REG_FRAMES = 2'd2;
  localparam logic [1:0] REG_LAST   = 2'd3;

  typedef logic [Q30_W-1:0] q30_t;
  typedef logic [255:0][Q30_W-1:0] etab_t;

  typedef struct packed {
    logic              done;
    logic [TERM_W-1:0] term;
  } exp_rsp_t;

  // floor(y / d) by shift and compare-subtract, used only for table and EXP_E1 build
  function automatic longint unsigned div_small(longint unsigned y, int unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((y >> b) & 64'd1);
      q   = q << 1;
      if (rem >= 64'(d)) begin
        rem = rem - 64'(d);
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // exp(-n/256) in Q1.30, 17-term Taylor series with truncation per term
  function automatic q30_t exp_neg_q30(int n);
    longint unsigned x;
    longint unsigned t;
    longint unsigned pos;
    longint unsigned neg;
    x   = longint'(n) << 22;
    t   = 64'd1 << 30;
    pos = 64'd1 << 30;
    neg = 64'd0;
    for (int m = 1; m <= 16; m++) begin
      t = div_small((t * x) >> 30, m);
      if ((m & 1) != 0) neg = neg + t;
      else pos = pos + t;
    end
    return q30_t'(pos - neg);
  endfunction

  function automatic etab_t build_etab();
    etab_t tab;
    for (int i = 0; i < 256; i++) tab[i] = exp_neg_q30(i);
    return tab;
  endfunction

  localparam etab_t ETAB   = build_etab();
  localparam q30_t  EXP_E1 = exp_neg_q30(256);

endpackage

@@ sv/ctcg_ram.sv @@
// ----------------------------------------------------------------------------
// ctcg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctcg_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/ctcg_exp.sv @@
// ----------------------------------------------------------------------------
// ctcg_exp
// Iterative exp term: table lookup, then repeated multiply by exp(-1) (high
// 16 bits in E_MA, low 15 bits in E_MB, per step), then round to Q1.16.
// ----------------------------------------------------------------------------
module ctcg_exp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ctcg_pkg::LOGIT_W-1:0]    k,
  output ctcg_pkg::exp_rsp_t              rsp
);
  import ctcg_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_MA   = 4'b0010,
    E_MB   = 4'b0100,
    E_FIN  = 4'b1000
  } exp_state_t;

  exp_state_t  state_r, state_nxt;
  q30_t        v_r, v_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        zero_r, zero_nxt;
  logic [46:0] acc_r, acc_nxt;
  logic [61:0] full;
  logic [31:0] rnd;

  assign full = {acc_r, 15'd0} + 62'(v_r[14:0] * EXP_E1);
  assign rnd  = 32'(v_r) + 32'd8192;

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      E_IDLE: begin
        if (start) begin
          zero_nxt = k > 16'd4096;
          v_nxt    = ETAB[k[7:0]];
          cnt_nxt  = k[12:8];
          state_nxt = (k > 16'd4096 || k[12:8] == 5'd0) ? E_FIN : E_MA;
        end
      end
      E_MA: begin
        acc_nxt   = 47'(v_r[30:15] * EXP_E1);
        state_nxt = E_MB;
      end
      E_MB: begin
        v_nxt     = full[60:30];
        cnt_nxt   = cnt_r - 5'd1;
        state_nxt = (cnt_r == 5'd1) ? E_FIN : E_MA;
      end
      E_FIN: state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    v_r    <= v_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done = state_r == E_FIN;
  assign rsp.term = zero_r ? '0 : rnd[30:14];

endmodule

@@ sv/ctcg_div.sv @@
// ----------------------------------------------------------------------------
// ctcg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctcg_div #(
  parameter int DVW = 33,
  parameter int DSW = 23
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] num,
  input  logic [DSW-1:0] den,
  output logic           done,
  output logic [DVW-1:0] quot
);

  localparam int CNTW = $clog2(DVW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DSW-1:0]  rem_r, rem_nxt;
  logic [DVW-1:0]  q_r, q_nxt;
  logic [DSW-1:0]  den_r, den_nxt;
  logic [DSW:0]    sh;
  logic            fit;

  assign sh  = {rem_r, q_r[DVW-1]};
  assign fit = sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = fit ? DSW'(sh - {1'b0, den_r}) : sh[DSW-1:0];
      q_nxt   = {q_r[DVW-2:0], fit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(DVW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ sv/ctc_greedy_decoder_top.sv @@
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_top
// Greedy CTC decoder over a stream of Q8.8 logits with per-sequence summary.
// ----------------------------------------------------------------------------
// Logits are taken one per cycle while a frame of V logits fills, V being
// vocab_size clamped to 2..MAX_VOCAB. When a frame closes the input stalls
// while the sequencer walks the frame store: each entry is read, then the
// shared exp unit does a table lookup and a multiply loop with one step per
// whole unit of (max - logit) (up to 16 steps); after the walk a 33-step
// serial division gives the frame probability. A sequence end adds another
// division for the mean. Each result is one transfer on the out_ channel; a
// token result precedes the summary when both occur.
module ctc_greedy_decoder_top #(
  parameter int MAX_VOCAB  = ctcg_pkg::DEF_MAX_VOCAB,
  parameter int MAX_FRAMES = ctcg_pkg::DEF_MAX_FRAMES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ctcg_pkg::LOGIT_W-1:0] in_logit,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_summary,
  output logic [ctcg_pkg::TOK_W-1:0]     out_token_index,
  output logic [ctcg_pkg::CONF_W-1:0]    out_confidence,
  output logic                           out_no_text,
  output logic                           out_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ctcg_pkg::PADDR_W-1:0]   paddr,
  input  logic [ctcg_pkg::PDATA_W-1:0]   pwdata,
  output logic [ctcg_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import ctcg_pkg::*;

  localparam int AW  = $clog2(MAX_VOCAB);
  localparam int CW  = $clog2(MAX_VOCAB + 1);
  localparam int FW  = $clog2(MAX_FRAMES + 1);
  localparam int SW  = TERM_W + $clog2(MAX_VOCAB);
  localparam int TW  = CONF_W + $clog2(MAX_FRAMES + 1);
  localparam int DSW = (SW > FW) ? SW : FW;

  typedef enum logic [9:0] {
    S_IN = 10'b0000000001,
    S_RD = 10'b0000000010,
    S_ST = 10'b0000000100,
    S_EW = 10'b0000001000,
    S_DP = 10'b0000010000,
    S_DW = 10'b0000100000,
    S_TK = 10'b0001000000,
    S_FE = 10'b0010000000,
    S_MW = 10'b0100000000,
    S_SM = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [5:0]  blank_r, last_tok_r;
  logic [6:0]  vocab_r;
  logic [10:0] frames_r;

  logic signed [LOGIT_W-1:0] best_r, best_nxt;
  logic [AW-1:0] bc_r, bc_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [FW-1:0] fc_r, fc_nxt;
  logic [AW-1:0] pt_r, pt_nxt;
  logic          pv_r, pv_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          emitted_r, emitted_nxt;
  logic [SW-1:0] sum_r, sum_nxt;

  logic            ov_r, ov_nxt;
  logic            o_sum_r, o_sum_nxt;
  logic [TOK_W-1:0]  o_tok_r, o_tok_nxt;
  logic [CONF_W-1:0] o_conf_r, o_conf_nxt;
  logic            o_nt_r, o_nt_nxt;

  logic [CW-1:0] veff;
  logic [FW-1:0] feff;
  logic          in_acc, out_free;
  logic [CW-1:0] cc_inc;
  logic [FW-1:0] fc_inc;

  logic [LOGIT_W-1:0] rdata;
  logic [LOGIT_W:0]   kdiff;
  logic               exp_start;
  exp_rsp_t           exp_rsp;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DSW-1:0]    div_den;
  logic [CONF_W-1:0] div_sat;

  logic tok_new, tok_text;

  // effective limits
  always_comb begin
    int v;
    int f;
    v = int'(vocab_r);
    f = int'(frames_r);
    if (v < 2) v = 2;
    if (v > MAX_VOCAB) v = MAX_VOCAB;
    if (f < 1) f = 1;
    if (f > MAX_FRAMES) f = MAX_FRAMES;
    veff = CW'(v);
    feff = FW'(f);
  end

  assign in_stall = state_r != S_IN;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;
  assign cc_inc   = cc_r + 1'b1;
  assign fc_inc   = fc_r + 1'b1;
  assign kdiff    = (LOGIT_W + 1)'(best_r) - (LOGIT_W + 1)'($signed(rdata));
  assign div_sat  = (div_quot > DIV_NW'(16'hFFFF)) ? 16'hFFFF : div_quot[CONF_W-1:0];
  assign tok_new  = !pv_r || pt_r != bc_r;
  assign tok_text = 32'(bc_r) != 32'(blank_r) && 32'(bc_r) <= 32'(last_tok_r);

  ctcg_ram #(.W(LOGIT_W), .D(MAX_VOCAB)) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (cc_r[AW-1:0]),
    .wdata (in_logit),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  ctcg_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (exp_start),
    .k     (kdiff[LOGIT_W-1:0]),
    .rsp   (exp_rsp)
  );

  ctcg_div #(.DVW(DIV_NW), .DSW(DSW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt   = state_r;
    best_nxt    = best_r;
    bc_nxt      = bc_r;
    cc_nxt      = cc_r;
    n_nxt       = n_r;
    idx_nxt     = idx_r;
    fc_nxt      = fc_r;
    pt_nxt      = pt_r;
    pv_nxt      = pv_r;
    total_nxt   = total_r;
    emitted_nxt = emitted_r;
    sum_nxt     = sum_r;
    ov_nxt      = ov_r && out_stall;
    o_sum_nxt   = o_sum_r;
    o_tok_nxt   = o_tok_r;
    o_conf_nxt  = o_conf_r;
    o_nt_nxt    = o_nt_r;
    exp_start   = 1'b0;
    div_start   = 1'b0;
    div_num     = DIV_NW'(64'h1_0000_0000);
    div_den     = (sum_r == '0) ? DSW'(1) : DSW'(sum_r);

    unique case (state_r)
      S_IN: begin
        if (in_acc) begin
          if (cc_r == '0 || in_logit > best_r) begin
            best_nxt = in_logit;
            bc_nxt   = cc_r[AW-1:0];
          end
          cc_nxt = cc_inc;
          if (cc_inc >= veff) begin
            n_nxt     = cc_inc;
            idx_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_ST;
      S_ST: begin
        exp_start = 1'b1;
        state_nxt = S_EW;
      end
      S_EW: begin
        if (exp_rsp.done) begin
          sum_nxt = sum_r + SW'(exp_rsp.term);
          idx_nxt = idx_r + 1'b1;
          state_nxt = (idx_r + 1'b1 >= n_r) ? S_DP : S_RD;
        end
      end
      S_DP: begin
        div_start = 1'b1;
        state_nxt = S_DW;
      end
      S_DW: begin
        if (div_done) begin
          total_nxt = total_r + TW'(div_sat);
          state_nxt = S_TK;
        end
      end
      S_TK: begin
        if (!(tok_new && tok_text) || out_free) begin
          if (tok_new) begin
            if (tok_text) begin
              ov_nxt      = 1'b1;
              o_sum_nxt   = 1'b0;
              o_tok_nxt   = TOK_W'(bc_r);
              o_conf_nxt  = '0;
              o_nt_nxt    = 1'b0;
              emitted_nxt = 1'b1;
            end
            pt_nxt = bc_r;
            pv_nxt = 1'b1;
          end
          cc_nxt    = '0;
          best_nxt  = '0;
          bc_nxt    = '0;
          state_nxt = S_FE;
        end
      end
      S_FE: begin
        fc_nxt = fc_inc;
        if (fc_inc >= feff) begin
          div_num   = DIV_NW'(total_r);
          div_den   = DSW'(fc_inc);
          div_start = 1'b1;
          state_nxt = S_MW;
        end else begin
          state_nxt = S_IN;
        end
      end
      S_MW: begin
        if (div_done) state_nxt = S_SM;
      end
      S_SM: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_sum_nxt   = 1'b1;
          o_tok_nxt   = '0;
          o_conf_nxt  = div_sat;
          o_nt_nxt    = !emitted_r;
          fc_nxt      = '0;
          pt_nxt      = '0;
          pv_nxt      = 1'b0;
          total_nxt   = '0;
          emitted_nxt = 1'b0;
          state_nxt   = S_IN;
        end
      end
      default: state_nxt = S_IN;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r    <= 6'(RST_BLANK);
      vocab_r    <= 7'(RST_VOCAB);
      frames_r   <= 11'(RST_FRAMES);
      last_tok_r <= 6'(RST_LAST);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_BLANK:  blank_r    <= pwdata[5:0];
        REG_VOCAB:  vocab_r    <= pwdata[6:0];
        REG_FRAMES: frames_r   <= pwdata[10:0];
        REG_LAST:   last_tok_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BLANK:  prdata = PDATA_W'(blank_r);
      REG_VOCAB:  prdata = PDATA_W'(vocab_r);
      REG_FRAMES: prdata = PDATA_W'(frames_r);
      REG_LAST:   prdata = PDATA_W'(last_tok_r);
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IN;
      best_r    <= '0;
      bc_r      <= '0;
      cc_r      <= '0;
      fc_r      <= '0;
      pt_r      <= '0;
      pv_r      <= 1'b0;
      total_r   <= '0;
      emitted_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      best_r    <= best_nxt;
      bc_r      <= bc_nxt;
      cc_r      <= cc_nxt;
      fc_r      <= fc_nxt;
      pt_r      <= pt_nxt;
      pv_r      <= pv_nxt;
      total_r   <= total_nxt;
      emitted_r <= emitted_nxt;
      ov_r      <= ov_nxt;
    end
    n_r      <= n_nxt;
    idx_r    <= idx_nxt;
    sum_r    <= sum_nxt;
    o_sum_r  <= o_sum_nxt;
    o_tok_r  <= o_tok_nxt;
    o_conf_r <= o_conf_nxt;
    o_nt_r   <= o_nt_nxt;
  end

  assign out_valid       = ov_r;
  assign out_is_summary  = o_sum_r;
  assign out_token_index = o_tok_r;
  assign out_confidence  = o_conf_r;
  assign out_no_text     = o_nt_r;
  assign out_last        = o_sum_r;

endmodule

@@ sim/ctc_greedy_decoder_top_test.sv @@
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_top_test
// Self-checking bench for the greedy CTC decoder: frames of logits in, token
// and summary transfers out, compared against an in-bench decode model.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ctcg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 3000;

  typedef struct {
    logic            is_summary;
    logic [TOK_W-1:0] token;
    logic [CONF_W-1:0] conf;
    logic            no_text;
    logic            last;
  } decode_t;

  typedef struct {
    logic [LOGIT_W-1:0] lg;
    int                 n;
    decode_t            r0;
    decode_t            r1;
  } row_t;

  typedef struct {
    int blank;
    int vocab;
    int frames;
    int last_tok;
    int items;
    int max_wait;
  } phase_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [LOGIT_W-1:0] in_logit = '0;
  logic out_valid;
  logic out_stall = 0;
  logic out_is_summary;
  logic [TOK_W-1:0] out_token_index;
  logic [CONF_W-1:0] out_confidence;
  logic out_no_text;
  logic out_last;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  ctc_greedy_decoder_top dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // decode model state
  int          logit_buf [64];
  int          top_score;
  int unsigned top_class;
  int unsigned n_class;
  int unsigned n_frame;
  int unsigned prev_tok;
  bit          prev_ok;
  int unsigned prob_acc;
  bit          any_text;
  int unsigned r_blank = RST_BLANK;
  int unsigned r_vocab = RST_VOCAB;
  int unsigned r_frames = RST_FRAMES;
  int unsigned r_last = RST_LAST;

  decode_t pending_q[$];
  int      errors = 0;
  int      idle_cycles = 0;
  int      out_max_wait = 10;
  int      in_max_wait = 10;

  function automatic longint unsigned exp_q30(int unsigned n);
    longint unsigned x, t, p, m;
    x = longint'(n) << 22;
    t = 64'd1 << 30;
    p = t;
    m = 0;
    for (int i = 1; i <= 16; i++) begin
      t = ((t * x) >> 30) / i;
      if (i % 2) m += t;
      else p += t;
    end
    return p - m;
  endfunction

  function automatic int unsigned exp_term(int unsigned k);
    longint unsigned v, e1;
    if (k > 4096) return 0;
    v = exp_q30(k & 255);
    e1 = exp_q30(256);
    repeat (k >> 8) v = (v * e1) >> 30;
    return int'((v + 8192) >> 14);
  endfunction

  function automatic void push_result(bit s, int unsigned tok, int unsigned conf,
                                      bit nt, bit l);
    decode_t r;
    r.is_summary = s;
    r.token = tok[TOK_W-1:0];
    r.conf = conf[CONF_W-1:0];
    r.no_text = nt;
    r.last = l;
    pending_q.push_back(r);
  endfunction

  // returns number of results the logit produces
  function automatic int decode_logit(logic [LOGIT_W-1:0] raw);
    int          lg;
    int unsigned veff, feff, sum, tok, mean;
    longint unsigned prob;
    int          cnt;
    lg = $signed(raw);
    cnt = 0;
    veff = r_vocab < 2 ? 2 : (r_vocab > DEF_MAX_VOCAB ? DEF_MAX_VOCAB : r_vocab);
    feff = r_frames < 1 ? 1 : (r_frames > DEF_MAX_FRAMES ? DEF_MAX_FRAMES : r_frames);
    if (n_class >= DEF_MAX_VOCAB) n_class = DEF_MAX_VOCAB - 1;
    logit_buf[n_class] = lg;
    if (n_class == 0 || lg > top_score) begin
      top_score = lg;
      top_class = n_class;
    end
    n_class++;
    if (n_class < veff) return 0;
    sum = 0;
    for (int i = 0; i < n_class; i++) sum += exp_term(top_score - logit_buf[i]);
    if (sum == 0) sum = 1;
    prob = (64'd1 << 32) / sum;
    if (prob > 65535) prob = 65535;
    prob_acc += int'(prob);
    tok = top_class;
    if (!prev_ok || tok != prev_tok) begin
      if (tok != r_blank && tok <= r_last) begin
        push_result(0, tok, 0, 0, 0);
        cnt++;
        any_text = 1;
      end
      prev_tok = tok;
      prev_ok = 1;
    end
    n_class = 0;
    top_score = 0;
    top_class = 0;
    n_frame++;
    if (n_frame >= feff) begin
      mean = prob_acc / n_frame;
      if (mean > 65535) mean = 65535;
      push_result(1, 0, mean, !any_text, 1);
      cnt++;
      n_frame = 0;
      prev_tok = 0;
      prev_ok = 0;
      prob_acc = 0;
      any_text = 0;
    end
    return cnt;
  endfunction

  // result side: random stall, transfer check, watchdog
  int stall_left = 0;
  always @(posedge clk) begin
    decode_t e;
    int w;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: summary=%0d tok=%0d conf=%0d",
                                     out_is_summary, out_token_index, out_confidence);
        end else begin
          e = pending_q.pop_front();
          if (out_is_summary !== e.is_summary || out_token_index !== e.token ||
              out_confidence !== e.conf || out_no_text !== e.no_text ||
              out_last !== e.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp s=%0d tok=%0d conf=%0d nt=%0d last=%0d",
                       e.is_summary, e.token, e.conf, e.no_text, e.last);
              $display("          got s=%0d tok=%0d conf=%0d nt=%0d last=%0d",
                       out_is_summary, out_token_index, out_confidence, out_no_text,
                       out_last);
            end
          end
        end
        w = $urandom_range(0, out_max_wait);
        stall_left <= w;
        out_stall <= (w != 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_BLANK:  r_blank = val & 63;
      REG_VOCAB:  r_vocab = val & 127;
      REG_FRAMES: r_frames = val & 2047;
      REG_LAST:   r_last = val & 63;
    endcase
  endtask

  task automatic send_logit(logic [LOGIT_W-1:0] v);
    int gap;
    gap = $urandom_range(0, in_max_wait);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_logit <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LOGIT_W-1:0] pick_logit();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  row_t   rows[$];
  phase_t phases[$];
  row_t   r;
  int     n;

  initial begin
    rows = '{
      '{16'h7FFF, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'h8000, 1, '{1, 0, 65535, 1, 1}, '{0, 0, 0, 0, 0}},
      '{16'h8000, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'h7FFF, 2, '{0, 1, 0, 0, 0}, '{1, 0, 65535, 0, 1}},
      '{16'h0005, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'h0005, 1, '{1, 0, 32768, 1, 1}, '{0, 0, 0, 0, 0}},
      '{16'h0000, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'hFFFF, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'h5555, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'hAAAA, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'h0100, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'h1100, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'h0001, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
      '{16'h0000, 0, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}}
    };
    // blank, vocab, frames, last, items, max wait
    phases = '{
      '{5, 4, 3, 40, 100, 10},
      '{63, 2, 2, 0, 60, 0},
      '{1, 0, 0, 63, 40, 10},
      '{0, 64, 2, 62, 160, 10},
      '{32, 127, 1, 63, 60, 3},
      '{2, 3, 5, 2, 80, 10},
      '{7, 6, 4, 20, 100, 10},
      '{1, 2, 1024, 1, 200, 2},
      '{0, 2, 2047, 63, 60, 10},
      '{3, 5, 7, 10, 1, 10},
      '{4, 8, 2, 30, 100, 10}
    };
    top_score = 0; top_class = 0; n_class = 0; n_frame = 0;
    prev_tok = 0; prev_ok = 0; prob_acc = 0; any_text = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    reg_write(REG_VOCAB, 2);
    reg_write(REG_FRAMES, 1);
    reg_write(REG_BLANK, 0);
    reg_write(REG_LAST, 63);
    foreach (rows[i]) begin
      r = rows[i];
      send_logit(r.lg);
      n = decode_logit(r.lg);
      if (r.n > 0) begin
        repeat (n) void'(pending_q.pop_back());
        pending_q.push_back(r.r0);
        if (r.n > 1) pending_q.push_back(r.r1);
      end
    end
    drain();

    foreach (phases[p]) begin
      reg_write(REG_BLANK, phases[p].blank | ($urandom & 32'hFFFF_FFC0));
      reg_write(REG_VOCAB, phases[p].vocab);
      reg_write(REG_FRAMES, phases[p].frames);
      reg_write(REG_LAST, phases[p].last_tok | ($urandom & 32'hFFFF_FFC0));
      in_max_wait = phases[p].max_wait;
      out_max_wait = phases[p].max_wait;
      for (int i = 0; i < phases[p].items; i++) begin
        logic [LOGIT_W-1:0] v;
        v = pick_logit();
        if ($urandom_range(0, 150) == 0) begin
          in_valid <= 0;
          while (pending_q.size() != 0) @(posedge clk);
        end
        send_logit(v);
        void'(decode_logit(v));
      end
      drain();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
